// File: rtl/crpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crpm_pkg
// Shared constants and controller/datapath types for the RMS and peak meter.
// ----------------------------------------------------------------------------
package crpm_pkg;

  localparam int AdcBits    = 10;
  localparam int AvgDepth   = 8;
  localparam int CountBits  = 16;
  localparam int IdxBits    = (AvgDepth > 1) ? $clog2(AvgDepth) : 1;
  localparam int FillBits   = $clog2(AvgDepth + 1);
  localparam int DevBits    = AdcBits + 1;
  localparam int RingSumBits = DevBits + $clog2(AvgDepth + 1);
  localparam int SqBits     = 2 * AdcBits + CountBits;
  localparam int CalBits    = AdcBits + CountBits;
  // Dividend of the end-of-window divide: square sum scaled by 256.
  localparam int DivBits    = SqBits + 8;
  localparam int DivCntBits = $clog2(DivBits + 1);
  localparam int RootBits   = DivBits / 2 + 1;
  localparam int RootCntBits = $clog2(RootBits + 1);
  localparam logic [CountBits-1:0] CountLimit = {CountBits{1'b1}};

  localparam logic OpMeasure = 1'b0;
  localparam logic OpCalib   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILTER,
    ST_ACCUM,
    ST_DIVIDE,
    ST_ROOT,
    ST_OUTPUT
  } state_t;

  // Divider operand selection.
  typedef enum logic [1:0] {
    DIV_RING,
    DIV_SQUARE,
    DIV_CALIB
  } div_sel_t;

  typedef struct packed {
    logic     load;       // capture input item, update counters
    logic     div_start;  // load divider operands
    div_sel_t div_sel;
    logic     div_step;
    logic     root_start;
    logic     root_step;
    logic     accum;      // fold filtered value into peak and square sum
    logic     finish;     // clear window state (result latched by out_valid_set)
    logic     out_valid_set;
  } crpm_cmd_t;

  typedef struct packed {
    logic     opcode;
    logic     last;
    logic     limited;    // count was at limit for this item
    logic     div_done;
    logic     root_done;
    logic     out_busy;
  } crpm_stat_t;

endpackage

`default_nettype wire

// File: rtl/crpm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crpm_ctrl
// Sequencer that steps the datapath through filter, divide and root phases.
// ----------------------------------------------------------------------------
module crpm_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_fire,
  input  crpm_pkg::crpm_stat_t stat,
  output logic                in_ready,
  output crpm_pkg::crpm_cmd_t cmd
);

  crpm_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      crpm_pkg::ST_IDLE: begin
        if (in_fire) state_next = crpm_pkg::ST_FILTER;
      end
      crpm_pkg::ST_FILTER: begin
        if (stat.limited) begin
          state_next = stat.last ? crpm_pkg::ST_ACCUM : crpm_pkg::ST_IDLE;
        end else if (stat.opcode == crpm_pkg::OpCalib) begin
          state_next = stat.last ? crpm_pkg::ST_ACCUM : crpm_pkg::ST_IDLE;
        end else begin
          state_next = crpm_pkg::ST_DIVIDE;
        end
      end
      // Window closing: start end-of-window divide.
      crpm_pkg::ST_ACCUM: state_next = crpm_pkg::ST_DIVIDE;
      crpm_pkg::ST_DIVIDE: begin
        if (stat.div_done) begin
          // The window divide leads to the root; the filter divide either ends the item or opens the window divide.
          if (second) begin
            state_next = crpm_pkg::ST_ROOT;
          end else begin
            state_next = stat.last ? crpm_pkg::ST_ACCUM : crpm_pkg::ST_IDLE;
          end
        end
      end
      crpm_pkg::ST_ROOT: begin
        if (stat.root_done) state_next = crpm_pkg::ST_OUTPUT;
      end
      crpm_pkg::ST_OUTPUT: begin
        if (!stat.out_busy) state_next = crpm_pkg::ST_IDLE;
      end
      default: state_next = crpm_pkg::ST_IDLE;
    endcase
  end

  // Phase tracking: a closing measure item under the limit divides twice (filter, then window).
  logic second, second_next;
  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else begin
      second <= second_next;
    end
  end

  always_comb begin
    second_next = second;
    if (state == crpm_pkg::ST_IDLE) second_next = 1'b0;
    else if (state == crpm_pkg::ST_ACCUM) second_next = 1'b1;
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    cmd.div_sel = crpm_pkg::DIV_RING;
    in_ready = (state == crpm_pkg::ST_IDLE);
    case (state)
      crpm_pkg::ST_IDLE: cmd.load = in_fire;
      crpm_pkg::ST_FILTER: begin
        if (!stat.limited && stat.opcode == crpm_pkg::OpMeasure) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = crpm_pkg::DIV_RING;
        end
      end
      crpm_pkg::ST_ACCUM: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = (stat.opcode == crpm_pkg::OpCalib) ? crpm_pkg::DIV_CALIB
                                                          : crpm_pkg::DIV_SQUARE;
      end
      crpm_pkg::ST_DIVIDE: begin
        cmd.div_step = !stat.div_done;
        if (stat.div_done && !second) cmd.accum = 1'b1;
        if (stat.div_done && second) cmd.root_start = 1'b1;
      end
      crpm_pkg::ST_ROOT: cmd.root_step = !stat.root_done;
      crpm_pkg::ST_OUTPUT: begin
        if (!stat.out_busy) begin
          cmd.finish = second;
          cmd.out_valid_set = second;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/crpm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crpm_dp
// Datapath: ring filter, accumulators, shared restoring divider and
// bit-pair square root, result register.
// ----------------------------------------------------------------------------
module crpm_dp (
  input  wire                          clk,
  input  wire                          rst,
  input  crpm_pkg::crpm_cmd_t          cmd,
  output crpm_pkg::crpm_stat_t         stat,
  input  wire                          in_opcode,
  input  wire [crpm_pkg::AdcBits-1:0]  in_sample,
  input  wire                          in_last,
  input  wire                          out_stall,
  output logic                         out_valid,
  output logic                         out_kind,
  output logic [crpm_pkg::AdcBits-1:0] out_peak,
  output logic [13:0]                  out_rms,
  output logic [crpm_pkg::AdcBits-1:0] out_offset,
  output logic                         out_ovf
);

  localparam int AB  = crpm_pkg::AdcBits;
  localparam int DB  = crpm_pkg::DivBits;
  localparam int RSB = crpm_pkg::RingSumBits;
  localparam int CB  = crpm_pkg::CountBits;

  // Captured item.
  logic            opc, lst, limited;
  logic [AB-1:0]   smp;

  // Persistent state.
  logic [AB-1:0]                   zero_offset;
  logic signed [crpm_pkg::DevBits-1:0] ring [crpm_pkg::AvgDepth];
  logic [crpm_pkg::IdxBits-1:0]    wr_idx;
  logic                            ring_full;
  logic signed [RSB-1:0]           ring_sum;
  logic [AB-1:0]                   peak;
  logic [crpm_pkg::SqBits-1:0]     sq_sum;
  logic [CB-1:0]                   meas_cnt, cal_cnt;
  logic [crpm_pkg::CalBits-1:0]    cal_sum;
  logic                            ovf_meas, ovf_cal;

  // Divider.
  logic [DB-1:0]                   dv_num, dv_rem;
  logic [DB-1:0]                   dv_den;
  logic [crpm_pkg::DivCntBits-1:0] dv_cnt;
  logic [DB:0]                     dv_trial;

  // Square root.
  logic [DB-1:0]                   rt_val, rt_res, rt_bit;
  logic [DB-1:0]                   rt_sum;

  logic signed [crpm_pkg::DevBits-1:0] dev;
  logic signed [RSB-1:0]           new_sum;
  logic [crpm_pkg::FillBits-1:0]   fill;
  logic [RSB-1:0]                  abs_sum;
  logic [AB-1:0]                   mag;
  logic [2*AB-1:0]                 mag_sq;
  logic [crpm_pkg::IdxBits:0]      idx_inc;

  assign dev = $signed({1'b0, smp}) - $signed({1'b0, zero_offset});
  assign new_sum = ring_sum + RSB'(dev)
                 - (ring_full ? RSB'(ring[wr_idx]) : RSB'(0));
  assign idx_inc = {1'b0, wr_idx} + 1'b1;
  assign fill = (ring_full || idx_inc == (crpm_pkg::IdxBits+1)'(crpm_pkg::AvgDepth))
              ? crpm_pkg::FillBits'(crpm_pkg::AvgDepth)
              : crpm_pkg::FillBits'(idx_inc);
  assign abs_sum = new_sum[RSB-1] ? RSB'(-new_sum) : RSB'(new_sum);
  // Quotient magnitude of the truncating divide equals |filtered value|.
  assign mag = AB'(dv_num);
  assign mag_sq = (2*AB)'(mag) * (2*AB)'(mag);

  assign dv_trial = {dv_rem[DB-2:0], dv_num[DB-1]} - {1'b0, dv_den};
  assign rt_sum = rt_res + rt_bit;

  assign stat.opcode    = opc;
  assign stat.last      = lst;
  assign stat.limited   = limited;
  assign stat.div_done  = (dv_cnt == '0);
  assign stat.root_done = (rt_bit == '0);
  assign stat.out_busy  = out_valid && out_stall;

  // Item capture and per-sample state.
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset <= AB'(1) << (AB - 1);
      wr_idx <= '0;
      ring_full <= 1'b0;
      ring_sum <= '0;
      peak <= '0;
      sq_sum <= '0;
      meas_cnt <= '0;
      cal_cnt <= '0;
      cal_sum <= '0;
      ovf_meas <= 1'b0;
      ovf_cal <= 1'b0;
      limited <= 1'b0;
    end else begin
      if (cmd.load) begin
        opc <= in_opcode;
        smp <= in_sample;
        lst <= in_last;
        if (in_opcode == crpm_pkg::OpCalib) begin
          if (cal_cnt == crpm_pkg::CountLimit) begin
            ovf_cal <= 1'b1;
            limited <= 1'b1;
          end else begin
            cal_sum <= cal_sum + crpm_pkg::CalBits'(in_sample);
            cal_cnt <= cal_cnt + 1'b1;
            limited <= 1'b0;
          end
        end else begin
          limited <= (meas_cnt == crpm_pkg::CountLimit);
          if (meas_cnt == crpm_pkg::CountLimit) ovf_meas <= 1'b1;
          else meas_cnt <= meas_cnt + 1'b1;
        end
      end
      // Ring update happens at filter-divide launch.
      if (cmd.div_start && cmd.div_sel == crpm_pkg::DIV_RING) begin
        ring[wr_idx] <= dev;
        ring_sum <= new_sum;
        wr_idx <= (idx_inc == (crpm_pkg::IdxBits+1)'(crpm_pkg::AvgDepth))
                  ? '0 : crpm_pkg::IdxBits'(idx_inc);
        if (idx_inc == (crpm_pkg::IdxBits+1)'(crpm_pkg::AvgDepth)) ring_full <= 1'b1;
      end
      if (cmd.accum) begin
        if (mag > peak) peak <= mag;
        sq_sum <= sq_sum + crpm_pkg::SqBits'(mag_sq);
      end
      // Calibration offset comes from the divider quotient.
      if (cmd.root_start && cmd.div_sel == crpm_pkg::DIV_RING && !cmd.accum
          && opc == crpm_pkg::OpCalib && cal_cnt != '0) begin
        zero_offset <= AB'(dv_num);
      end
      if (cmd.finish) begin
        if (opc == crpm_pkg::OpCalib) begin
          cal_sum <= '0;
          cal_cnt <= '0;
          ovf_cal <= 1'b0;
        end else begin
          peak <= '0;
          sq_sum <= '0;
          meas_cnt <= '0;
          ovf_meas <= 1'b0;
        end
      end
    end
  end

  // Restoring divider, one quotient bit per cycle; quotient in dv_num.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= '0;
    end else if (cmd.div_start) begin
      dv_rem <= '0;
      dv_cnt <= crpm_pkg::DivCntBits'(DB);
      case (cmd.div_sel)
        crpm_pkg::DIV_RING: begin
          dv_num <= DB'(abs_sum);
          dv_den <= DB'(fill);
        end
        crpm_pkg::DIV_SQUARE: begin
          dv_num <= {sq_sum, 8'd0};
          dv_den <= (meas_cnt == '0) ? DB'(1) : DB'(meas_cnt);
        end
        crpm_pkg::DIV_CALIB: begin
          dv_num <= DB'({cal_sum, 1'b0}) + DB'(cal_cnt);
          dv_den <= (cal_cnt == '0) ? DB'(1) : DB'({cal_cnt, 1'b0});
        end
        default: begin
          dv_num <= '0;
          dv_den <= DB'(1);
        end
      endcase
    end else if (cmd.div_step) begin
      dv_cnt <= dv_cnt - 1'b1;
      if (!dv_trial[DB]) begin
        dv_rem <= dv_trial[DB-1:0];
        dv_num <= {dv_num[DB-2:0], 1'b1};
      end else begin
        dv_rem <= {dv_rem[DB-2:0], dv_num[DB-1]};
        dv_num <= {dv_num[DB-2:0], 1'b0};
      end
    end
  end

  // Digit-by-digit integer square root, one result bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      rt_val <= dv_num;
      rt_res <= '0;
      rt_bit <= DB'(1) << ((DB - 1) & ~1);
    end else if (cmd.root_step) begin
      if (rt_val >= rt_sum) begin
        rt_val <= rt_val - rt_sum;
        rt_res <= (rt_res >> 1) + rt_bit;
      end else begin
        rt_res <= rt_res >> 1;
      end
      rt_bit <= rt_bit >> 2;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.out_valid_set) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_valid_set) begin
      out_kind <= opc;
      out_offset <= zero_offset;
      if (opc == crpm_pkg::OpCalib) begin
        out_peak <= '0;
        out_rms <= '0;
        out_ovf <= ovf_cal;
      end else begin
        out_peak <= peak;
        out_rms <= (meas_cnt == '0) ? 14'd0 : rt_res[13:0];
        out_ovf <= ovf_meas;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/current_rms_peak_meter.sv
`default_nettype none
// A closing measurement item runs the filter divide, the window divide of the
// square sum, the square root and the result register; a closing calibration item,
// or one past the count limit, skips the filter divide. A measurement item within
// the limit holds the input through the 44-step divide of the ring sum.
// One item is in flight at a time; a stalled result adds its stall cycles.
// Synchronous reset clears the offset to mid-scale and all counters.
// ----------------------------------------------------------------------------
// current_rms_peak_meter
// Top level: RMS and peak meter with zero calibration and moving average.
// ----------------------------------------------------------------------------
module current_rms_peak_meter (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          opcode,
  input  wire [crpm_pkg::AdcBits-1:0]  sample,
  input  wire                          last,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         result_kind,
  output logic [crpm_pkg::AdcBits-1:0] peak_counts,
  output logic [13:0]                  rms_counts_q4,
  output logic [crpm_pkg::AdcBits-1:0] zero_offset_out,
  output logic                         count_overflow
);

  crpm_pkg::crpm_cmd_t  cmd;
  crpm_pkg::crpm_stat_t stat;
  logic                 in_ready;
  logic                 in_fire;

  assign in_stall = !in_ready;
  assign in_fire  = in_valid && in_ready;

  crpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  crpm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_opcode  (opcode),
    .in_sample  (sample),
    .in_last    (last),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_kind   (result_kind),
    .out_peak   (peak_counts),
    .out_rms    (rms_counts_q4),
    .out_offset (zero_offset_out),
    .out_ovf    (count_overflow)
  );

`ifndef SYNTHESIS
  // A new item is never taken while the sequencer is busy.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> in_ready)
    else $error("item loaded while busy");

  // A result is only set up when the output register is free.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_valid_set |-> !(out_valid && out_stall))
    else $error("result overwrite");

  // Divide and root steps never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.div_step && cmd.root_step))
    else $error("divider and root active together");
`endif

endmodule

`default_nettype wire
